// File: rtl/mmn_pkg.sv
// mmn_pkg: shared types for the min/max normalizer.
// Job descriptor, result item and back-end state encoding.
// No dependencies.
`default_nettype none

package mmn_pkg;

    localparam int SAMPLE_W = 16;
    localparam int NORM_W   = 17;
    localparam int DIV_STEPS = 17;   // one quotient bit per step

    // Block summary handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] min_val;
        logic [SAMPLE_W-1:0] max_val;
        logic                dropped;
    } t_job;

    // One result item
    typedef struct packed {
        logic [NORM_W-1:0] norm;
        logic              last;
        logic              dropped;
    } t_result;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_DIV,
        BK_PUSH
    } t_back_state;

endpackage

`default_nettype wire

// File: rtl/mmn_front.sv
// mmn_front: accepts samples, stores or drops them, tracks min/max and count.
// Emits a job to mmn_buf on the last sample. Uses mmn_pkg.
`default_nettype none

module mmn_front #(
    parameter int MAX_SAMPLES = 64,
    parameter int CNT_W       = 7,
    parameter int IDX_W       = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [mmn_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                          i_last_sample,
    output logic                               o_wr_en,
    output logic [IDX_W-1:0]                   o_wr_idx,
    output logic [mmn_pkg::SAMPLE_W-1:0]       o_wr_data,
    output logic                               o_job_push,
    output mmn_pkg::t_job                      o_job,
    output logic [CNT_W-1:0]                   o_job_cnt
);

    logic [CNT_W-1:0]             r_count, n_count;
    logic [mmn_pkg::SAMPLE_W-1:0] r_min, n_min;
    logic [mmn_pkg::SAMPLE_W-1:0] r_max, n_max;
    logic                         r_ovf, n_ovf;
    logic                         store_ok;

    assign store_ok = (r_count < CNT_W'(MAX_SAMPLES));

    always_comb begin
        n_count = r_count;
        n_min   = r_min;
        n_max   = r_max;
        n_ovf   = r_ovf;
        if (store_ok) begin
            n_count = r_count + CNT_W'(1);
            if (r_count == '0) begin
                n_min = i_sample;
                n_max = i_sample;
            end else begin
                if ($signed(i_sample) < $signed(r_min)) n_min = i_sample;
                if ($signed(i_sample) > $signed(r_max)) n_max = i_sample;
            end
        end else begin
            n_ovf = 1'b1;   // store full: sample discarded
        end
    end

    assign o_wr_en    = i_accept && store_ok;
    assign o_wr_idx   = r_count[IDX_W-1:0];
    assign o_wr_data  = i_sample;
    assign o_job_push = i_accept && i_last_sample;
    assign o_job      = '{min_val: n_min, max_val: n_max, dropped: n_ovf};
    assign o_job_cnt  = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_last_sample) begin
                r_count <= '0;
                r_min   <= '0;
                r_max   <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_min   <= n_min;
                r_max   <= n_max;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/mmn_buf.sv
// mmn_buf: two-bank sample memory plus a two-entry job queue between the
// front and back parts. Each queued job owns one bank. Uses mmn_pkg.
`default_nettype none

module mmn_buf #(
    parameter int CNT_W = 7,
    parameter int IDX_W = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // front side
    input  wire logic                          i_wr_en,
    input  wire logic [IDX_W-1:0]              i_wr_idx,
    input  wire logic [mmn_pkg::SAMPLE_W-1:0]  i_wr_data,
    input  wire logic                          i_job_push,
    input  wire mmn_pkg::t_job                 i_job,
    input  wire logic [CNT_W-1:0]              i_job_cnt,
    output logic                               o_job_full,
    output logic                               o_wr_bank,
    // back side
    input  wire logic                          i_rd_en,
    input  wire logic [IDX_W-1:0]              i_rd_idx,
    output logic [mmn_pkg::SAMPLE_W-1:0]       o_rd_data,
    input  wire logic                          i_job_pop,
    output logic                               o_job_valid,
    output mmn_pkg::t_job                      o_job,
    output logic [CNT_W-1:0]                   o_job_cnt,
    output logic                               o_rd_bank
);

    localparam int DEPTH = 2 * (2 ** IDX_W);

    logic [mmn_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [mmn_pkg::SAMPLE_W-1:0] r_rd_data;

    mmn_pkg::t_job    r_jobs [2];
    logic [CNT_W-1:0] r_cnts [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_used;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) mem[{r_wr_ptr, i_wr_idx}] <= i_wr_data;
        if (i_rd_en) r_rd_data <= mem[{r_rd_ptr, i_rd_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (i_job_push) begin
            r_jobs[r_wr_ptr] <= i_job;
            r_cnts[r_wr_ptr] <= i_job_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_used   <= 2'd0;
        end else begin
            if (i_job_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_job_pop)  r_rd_ptr <= ~r_rd_ptr;
            if (i_job_push && !i_job_pop)      r_used <= r_used + 2'd1;
            else if (!i_job_push && i_job_pop) r_used <= r_used - 2'd1;
        end
    end

    assign o_job_full  = (r_used == 2'd2);
    assign o_job_valid = (r_used != 2'd0);
    assign o_job       = r_jobs[r_rd_ptr];
    assign o_job_cnt   = r_cnts[r_rd_ptr];
    assign o_rd_data   = r_rd_data;
    assign o_wr_bank   = r_wr_ptr;
    assign o_rd_bank   = r_rd_ptr;

endmodule

`default_nettype wire

// File: rtl/mmn_back.sv
// mmn_back: walks the head job's samples and divides each one with a
// one-bit-per-cycle restoring divider. Uses mmn_pkg.
`default_nettype none

module mmn_back #(
    parameter int CNT_W = 7,
    parameter int IDX_W = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_valid,
    input  wire mmn_pkg::t_job                 i_job,
    input  wire logic [CNT_W-1:0]              i_job_cnt,
    output logic                               o_job_pop,
    output logic                               o_rd_en,
    output logic [IDX_W-1:0]                   o_rd_idx,
    input  wire logic [mmn_pkg::SAMPLE_W-1:0]  i_rd_data,
    input  wire logic                          i_res_full,
    output logic                               o_res_push,
    output mmn_pkg::t_result                   o_res
);

    localparam int STEP_W = $clog2(mmn_pkg::DIV_STEPS);

    mmn_pkg::t_back_state       r_state, n_state;
    logic [IDX_W-1:0]           r_idx;
    logic [mmn_pkg::NORM_W-1:0] r_rem, r_quo;
    logic [STEP_W-1:0]          r_step;

    logic [mmn_pkg::SAMPLE_W-1:0] den, num;
    logic [mmn_pkg::NORM_W-1:0]   diff;
    logic                         ge, is_last;

    assign den = i_job.max_val - i_job.min_val;
    assign num = i_rd_data - i_job.min_val;
    assign ge  = (den != '0) && (r_rem >= {1'b0, den});
    assign diff = ge ? (r_rem - {1'b0, den}) : r_rem;
    assign is_last = (CNT_W'(r_idx) == CNT_W'(i_job_cnt - CNT_W'(1)));

    assign o_rd_idx = r_idx;
    assign o_res    = '{norm: r_quo, last: is_last, dropped: i_job.dropped};

    always_comb begin
        n_state    = r_state;
        o_rd_en    = 1'b0;
        o_res_push = 1'b0;
        o_job_pop  = 1'b0;
        case (r_state)
            mmn_pkg::BK_IDLE: begin
                if (i_job_valid) n_state = mmn_pkg::BK_READ;
            end
            mmn_pkg::BK_READ: begin
                o_rd_en = 1'b1;
                n_state = mmn_pkg::BK_LOAD;
            end
            mmn_pkg::BK_LOAD: begin
                n_state = mmn_pkg::BK_DIV;
            end
            mmn_pkg::BK_DIV: begin
                if (r_step == STEP_W'(mmn_pkg::DIV_STEPS - 1)) n_state = mmn_pkg::BK_PUSH;
            end
            mmn_pkg::BK_PUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (is_last) begin
                        o_job_pop = 1'b1;
                        n_state   = mmn_pkg::BK_IDLE;
                    end else begin
                        n_state = mmn_pkg::BK_READ;
                    end
                end
            end
            default: n_state = mmn_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mmn_pkg::BK_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (r_state == mmn_pkg::BK_IDLE) begin
            r_idx <= '0;
        end else if (o_res_push && !is_last) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mmn_pkg::BK_LOAD: begin
                r_rem  <= {1'b0, num};
                r_quo  <= '0;
                r_step <= '0;
            end
            mmn_pkg::BK_DIV: begin
                r_rem  <= {diff[mmn_pkg::NORM_W-2:0], 1'b0};
                r_quo  <= {r_quo[mmn_pkg::NORM_W-2:0], ge};
                r_step <= r_step + STEP_W'(1);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mmn_outq.sv
// mmn_outq: two-entry result queue in front of the output ports.
// Uses mmn_pkg::t_result.
`default_nettype none

module mmn_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mmn_pkg::t_result  i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output mmn_pkg::t_result       o_data
);

    mmn_pkg::t_result r_data [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_used;
    logic             do_push, do_pop;

    assign o_full  = (r_used == 2'd2);
    assign o_empty = (r_used == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_data[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_used   <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            if (do_push && !do_pop)      r_used <= r_used + 2'd1;
            else if (!do_push && do_pop) r_used <= r_used - 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/min_max_normalizer.sv
// min_max_normalizer: top level, min-max normalization of sample blocks.
// Instantiates mmn_front, mmn_buf, mmn_back, mmn_outq; types from mmn_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | i_sample[15:0] signed, i_last_sample
//  result   | pop / empty        | o_norm_value[16:0], o_last_result, o_dropped
//
// Samples enter one per cycle while full is low. Each result passes through the
// back part in order: memory read, operand load, 17 steps of the bit-serial divider, push.
// Two sample banks: a new block loads while the previous one is emitted;
// full stays high only while two finished blocks own both banks.
// Reset is synchronous, active low; the sample memory needs no clearing pass.
// A stalled result side fills the two-entry result queue, then holds the back
// part at its push; the front keeps loading until both banks are taken.
`default_nettype none

module min_max_normalizer #(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [15:0]   i_sample,
    input  wire logic          i_last_sample,
    input  wire logic          pop,
    output logic               empty,
    output logic [16:0]        o_norm_value,
    output logic               o_last_result,
    output logic               o_dropped
);

    // count must hold MAX_SAMPLES itself; index needs at least one bit
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    logic                         accept;
    logic                         wr_en, rd_en;
    logic [IDX_W-1:0]             wr_idx, rd_idx;
    logic [mmn_pkg::SAMPLE_W-1:0] wr_data, rd_data;
    logic                         job_push, job_pop, job_full, job_valid;
    mmn_pkg::t_job                front_job, head_job;
    logic [CNT_W-1:0]             front_cnt, head_cnt;
    logic                         wr_bank, rd_bank;
    logic                         res_push, res_full;
    mmn_pkg::t_result             res_in, res_out;

    // item taken when the job queue still has a free bank
    assign full   = job_full;
    assign accept = push && !job_full;

    mmn_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_wr_en       (wr_en),
        .o_wr_idx      (wr_idx),
        .o_wr_data     (wr_data),
        .o_job_push    (job_push),
        .o_job         (front_job),
        .o_job_cnt     (front_cnt)
    );

    mmn_buf #(
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_idx    (wr_idx),
        .i_wr_data   (wr_data),
        .i_job_push  (job_push),
        .i_job       (front_job),
        .i_job_cnt   (front_cnt),
        .o_job_full  (job_full),
        .o_wr_bank   (wr_bank),
        .i_rd_en     (rd_en),
        .i_rd_idx    (rd_idx),
        .o_rd_data   (rd_data),
        .i_job_pop   (job_pop),
        .o_job_valid (job_valid),
        .o_job       (head_job),
        .o_job_cnt   (head_cnt),
        .o_rd_bank   (rd_bank)
    );

    mmn_back #(
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .i_job_cnt   (head_cnt),
        .o_job_pop   (job_pop),
        .o_rd_en     (rd_en),
        .o_rd_idx    (rd_idx),
        .i_rd_data   (rd_data),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    mmn_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_norm_value  = res_out.norm;
    assign o_last_result = res_out.last;
    assign o_dropped     = res_out.dropped;

    // front never writes the bank the back part is reading
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en && job_valid) |-> (wr_bank != rd_bank))
        else $error("front write hits bank under readout");

    // a job retires only together with its last result
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> (res_push && res_in.last))
        else $error("job retired without last result");

    // quotient never exceeds 1.0
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (res_in.norm <= 17'h10000))
        else $error("normalized value above 1.0");

    // the back part only walks a job that is queued
    a_read_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> job_valid)
        else $error("sample read with no job queued");

endmodule

`default_nettype wire
